[rtl/core/vss_pkg.sv]
// Shared types and constants of the valve step sequencer.
package vss_pkg;

    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int DEN_W     = 28;
    localparam int DIV_STEPS = 28;
    localparam int FRAC_BITS = 12;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_INTERVAL = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_INTERVAL = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ERROR_GAIN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_CLOSE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_OPEN         = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_DEFROST_OPEN = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOSE_INC    = 3'd7;

    localparam logic [15:0] RST_MIN_INTERVAL = 16'd500;
    localparam logic [15:0] RST_MAX_INTERVAL = 16'd10000;
    localparam logic [15:0] RST_ERROR_GAIN   = 16'd154;
    localparam logic [15:0] RST_SETTLE       = 16'd8000;
    localparam logic [15:0] RST_INIT_CLOSE   = 16'd500;
    localparam logic [15:0] RST_OPEN         = 16'd250;
    localparam logic [15:0] RST_DEFROST_OPEN = 16'd500;
    localparam logic [7:0]  RST_CLOSE_INC    = 8'd16;

    localparam logic [2:0] VS_INIT      = 3'd0;
    localparam logic [2:0] VS_CLOSING   = 3'd1;
    localparam logic [2:0] VS_OPENING   = 3'd2;
    localparam logic [2:0] VS_REGULATE  = 3'd3;
    localparam logic [2:0] VS_IDLE      = 3'd4;

    typedef enum logic [4:0] {
        SQ_INIT     = 5'b00001,
        SQ_CLOSING  = 5'b00010,
        SQ_OPENING  = 5'b00100,
        SQ_REGULATE = 5'b01000,
        SQ_IDLE     = 5'b10000
    } t_seq_state;

    typedef enum logic [3:0] {
        CT_IDLE = 4'b0001,
        CT_PREP = 4'b0010,
        CT_WORK = 4'b0100,
        CT_OUT  = 4'b1000
    } t_ctl_state;

    typedef struct packed {
        logic start;
        logic clear;
        logic push;
    } t_ring_ctl;

    function automatic logic [2:0] seq_code(input t_seq_state s);
        logic [2:0] c;
        c = VS_INIT;
        unique case (s)
            SQ_INIT:     c = VS_INIT;
            SQ_CLOSING:  c = VS_CLOSING;
            SQ_OPENING:  c = VS_OPENING;
            SQ_REGULATE: c = VS_REGULATE;
            SQ_IDLE:     c = VS_IDLE;
            default:     c = VS_INIT;
        endcase
        return c;
    endfunction

endpackage

[rtl/core/valve_step_sequencer_core.sv]
// Top level of the expansion-valve stepper sequencer.
// Usage: the input channel (i_in_valid, o_in_stall) carries either a push of a
// signed step request (i_cmd high) or a one-millisecond tick (i_cmd low). Every
// item gives exactly one result on the output channel (o_out_valid, i_out_stall)
// with the move flag, the relative move, the sequencer state and the position.
// A push is stored in the request ring. For a tick, the ring is read one
// entry per cycle through its single read port while a bit-serial divider
// works out the move interval alongside. One item is in work at a time; the
// next is taken as soon as its result sits in the output register.
// Configuration registers are written through i_cfg_we, i_cfg_index and
// i_cfg_data while the block is idle; the user must keep to this, as the
// block itself does not enforce it. Synchronous reset loads the register
// defaults, empties the ring, clears the output valid flag and puts the
// sequencer in its initial state. While the receiver stalls, the result is
// held in the output register and one further item may be taken and worked on.
module valve_step_sequencer_core #(
    parameter int RING_DEPTH    = 64,
    parameter int REQUEST_WIDTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [vss_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [vss_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_cmd,
    input  logic signed [15:0]            i_step_request,
    input  logic                          i_run_request,
    input  logic                          i_defrost_request,
    input  logic                          i_motor_busy,
    input  logic [11:0]                   i_abs_error,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_move_valid,
    output logic signed [16:0]            o_move_steps,
    output logic [2:0]                    o_valve_state,
    output logic [15:0]                   o_position
);
    import vss_pkg::*;

    localparam logic signed [32:0] REQ_HI = 33'((64'sd1 <<< (REQUEST_WIDTH - 1)) - 64'sd1);
    localparam logic signed [32:0] REQ_LO = -REQ_HI - 33'sd1;
    localparam logic signed [32:0] MOVE_HI = 33'sd65535;
    localparam logic signed [32:0] MOVE_LO = -33'sd65536;

    logic [15:0] r_min, r_max, r_gain, r_settle_ms, r_init, r_open, r_dopen;
    logic [7:0]  r_inc;

    t_ctl_state r_ctl, n_ctl;
    t_seq_state r_seq, n_seq;
    logic        r_fcp, n_fcp, r_latch, n_latch;
    logic [15:0] r_pos, n_pos, r_settle, n_settle, r_interval, n_interval;

    logic        r_cmd, r_run, r_defrost, r_busy;
    logic [11:0] r_abs_err;

    logic              r_ov, r_mv;
    logic signed [16:0] r_ms;
    logic [2:0]        r_vs;
    logic [15:0]       r_op;

    logic                            in_acc, can_load, div_busy, scan_busy, clear;
    logic                            n_mv;
    logic signed [16:0]              n_ms;
    logic [15:0]                     quot, span;
    logic [DEN_W-1:0]                prod, den;
    logic [16:0]                     delay;
    logic signed [32:0]              req_ext, best_ext;
    logic signed [REQUEST_WIDTH-1:0] push_data, best;
    t_ring_ctl                       ring_ctl;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign o_in_stall = r_ctl != CT_IDLE;
    assign can_load = !r_ov || !i_out_stall;

    assign req_ext   = 33'(i_step_request);
    assign push_data = (req_ext > REQ_HI) ? REQUEST_WIDTH'(REQ_HI) :
                       (req_ext < REQ_LO) ? REQUEST_WIDTH'(REQ_LO) :
                       REQUEST_WIDTH'(req_ext);

    assign span  = r_max - r_min;
    assign prod  = r_gain * r_abs_err;
    assign den   = prod + DEN_W'(4096);
    assign delay = (r_max <= r_min) ? {1'b0, r_min} : {1'b0, r_min} + {1'b0, quot};

    assign best_ext = 33'(best);

    assign ring_ctl.start = r_ctl == CT_PREP;
    assign ring_ctl.clear = (r_ctl == CT_OUT) && can_load && clear;
    assign ring_ctl.push  = in_acc && i_cmd;

    vss_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_ctl == CT_PREP),
        .i_span  (span),
        .i_den   (den),
        .o_busy  (div_busy),
        .o_quot  (quot)
    );

    vss_ring #(
        .RING_DEPTH    (RING_DEPTH),
        .REQUEST_WIDTH (REQUEST_WIDTH)
    ) u_ring (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ring_ctl),
        .i_push_data (push_data),
        .o_busy      (scan_busy),
        .o_best      (best)
    );

    always_comb begin
        n_seq      = r_seq;
        n_fcp      = r_fcp;
        n_latch    = r_latch;
        n_pos      = r_pos;
        n_settle   = r_settle;
        n_interval = r_interval;
        n_mv       = 1'b0;
        n_ms       = '0;
        clear      = 1'b0;
        if (!r_cmd) begin
            if (r_defrost) begin
                if (!r_latch && !r_busy) begin
                    n_latch = 1'b1;
                    n_pos   = '0;
                    n_mv    = 1'b1;
                    n_ms    = -$signed({1'b0, r_dopen});
                    n_seq   = SQ_OPENING;
                end
            end else begin
                n_latch = 1'b0;
                unique case (r_seq)
                    SQ_CLOSING: begin
                        if (!r_busy) begin
                            if (r_fcp && r_run) begin
                                n_mv  = 1'b1;
                                n_ms  = -$signed({1'b0, r_open});
                                n_seq = SQ_OPENING;
                            end else begin
                                n_seq = SQ_IDLE;
                            end
                            n_fcp = 1'b0;
                        end
                    end
                    SQ_IDLE: begin
                        if (!r_busy && r_run) begin
                            n_mv  = 1'b1;
                            n_ms  = -$signed({1'b0, r_open});
                            n_seq = SQ_OPENING;
                        end
                    end
                    SQ_OPENING: begin
                        if (!r_busy) begin
                            n_settle = '0;
                            n_seq    = SQ_REGULATE;
                        end
                    end
                    SQ_REGULATE: begin
                        if (!r_run) begin
                            n_pos = r_pos + 16'(r_inc);
                            n_mv  = 1'b1;
                            n_ms  = $signed({1'b0, n_pos});
                            n_seq = SQ_CLOSING;
                        end else if (r_settle >= r_settle_ms && !r_busy &&
                                     {1'b0, r_interval} >= delay) begin
                            n_mv       = 1'b1;
                            n_ms       = (best_ext > MOVE_HI) ? 17'sd65535 :
                                         (best_ext < MOVE_LO) ? -17'sd65536 :
                                         17'(best_ext);
                            clear      = 1'b1;
                            n_interval = '0;
                        end
                    end
                    default: begin
                        if (!r_busy) begin
                            n_pos = r_init;
                            n_mv  = 1'b1;
                            n_ms  = $signed({1'b0, r_init});
                            n_seq = SQ_CLOSING;
                            n_fcp = 1'b1;
                        end
                    end
                endcase
            end
        end
    end

    always_comb begin
        n_ctl = r_ctl;
        unique case (r_ctl)
            CT_IDLE: if (in_acc) n_ctl = i_cmd ? CT_OUT : CT_PREP;
            CT_PREP: n_ctl = CT_WORK;
            CT_WORK: if (!div_busy && !scan_busy) n_ctl = CT_OUT;
            CT_OUT:  if (can_load) n_ctl = CT_IDLE;
            default: n_ctl = CT_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min       <= RST_MIN_INTERVAL;
            r_max       <= RST_MAX_INTERVAL;
            r_gain      <= RST_ERROR_GAIN;
            r_settle_ms <= RST_SETTLE;
            r_init      <= RST_INIT_CLOSE;
            r_open      <= RST_OPEN;
            r_dopen     <= RST_DEFROST_OPEN;
            r_inc       <= RST_CLOSE_INC;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MIN_INTERVAL: r_min       <= i_cfg_data;
                CFG_MAX_INTERVAL: r_max       <= i_cfg_data;
                CFG_ERROR_GAIN:   r_gain      <= i_cfg_data;
                CFG_SETTLE:       r_settle_ms <= i_cfg_data;
                CFG_INIT_CLOSE:   r_init      <= i_cfg_data;
                CFG_OPEN:         r_open      <= i_cfg_data;
                CFG_DEFROST_OPEN: r_dopen     <= i_cfg_data;
                CFG_CLOSE_INC:    r_inc       <= i_cfg_data[7:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cmd     <= i_cmd;
            r_run     <= i_run_request;
            r_defrost <= i_defrost_request;
            r_busy    <= i_motor_busy;
            r_abs_err <= i_abs_error;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl      <= CT_IDLE;
            r_seq      <= SQ_INIT;
            r_fcp      <= 1'b0;
            r_latch    <= 1'b0;
            r_pos      <= '0;
            r_settle   <= '0;
            r_interval <= '0;
            r_ov       <= 1'b0;
        end else begin
            r_ctl <= n_ctl;
            if (in_acc && !i_cmd) begin
                if (r_settle != 16'hFFFF) r_settle <= r_settle + 16'd1;
                if (r_interval != 16'hFFFF) r_interval <= r_interval + 16'd1;
            end
            if ((r_ctl == CT_OUT) && can_load) begin
                r_seq      <= n_seq;
                r_fcp      <= n_fcp;
                r_latch    <= n_latch;
                r_pos      <= n_pos;
                r_settle   <= n_settle;
                r_interval <= n_interval;
                r_ov       <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_ctl == CT_OUT) && can_load) begin
            r_mv <= n_mv;
            r_ms <= n_ms;
            r_vs <= seq_code(n_seq);
            r_op <= n_pos;
        end
    end

    assign o_out_valid   = r_ov;
    assign o_move_valid  = r_mv;
    assign o_move_steps  = r_ms;
    assign o_valve_state = r_vs;
    assign o_position    = r_op;

`ifndef NO_ASSERTIONS
    a_stall_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_in_stall)
        else $error("input taken while an item is still in work");
    a_units_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (div_busy || scan_busy) |-> (r_ctl == CT_WORK))
        else $error("divider or scan running outside the work phase");
    a_no_move_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_move_valid) |-> (o_move_steps == 17'sd0))
        else $error("non-zero move without the move flag");
    a_clear_on_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ring_ctl.clear |=> (o_out_valid && o_move_valid && r_interval == 16'd0))
        else $error("ring cleared without a regulation move");
`endif

endmodule

[rtl/core/vss_div.sv]
// Bit-serial restoring divider for the regulation move interval.
module vss_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [15:0]               i_span,
    input  logic [vss_pkg::DEN_W-1:0] i_den,
    output logic                      o_busy,
    output logic [15:0]               o_quot
);
    import vss_pkg::*;

    logic [DEN_W-1:0] r_num, r_den, r_rem;
    logic [15:0]      r_quot;
    logic [4:0]       r_cnt;
    logic [DEN_W:0]   rem_sh;
    logic             q_bit;

    assign rem_sh = {r_rem, r_num[DEN_W-1]};
    assign q_bit  = rem_sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= 5'(DIV_STEPS);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 5'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num  <= {i_span, {FRAC_BITS{1'b0}}};
            r_den  <= i_den;
            r_rem  <= '0;
            r_quot <= '0;
        end else if (r_cnt != '0) begin
            r_num  <= {r_num[DEN_W-2:0], 1'b0};
            r_rem  <= q_bit ? DEN_W'(rem_sh - {1'b0, r_den}) : rem_sh[DEN_W-1:0];
            r_quot <= {r_quot[14:0], q_bit};
        end
    end

    assign o_busy = r_cnt != '0;
    assign o_quot = r_quot;

endmodule

[rtl/core/vss_ring.sv]
// Request ring memory with valid bits and an entry-serial largest-magnitude scan.
module vss_ring #(
    parameter int RING_DEPTH    = 64,
    parameter int REQUEST_WIDTH = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  vss_pkg::t_ring_ctl              i_ctl,
    input  logic signed [REQUEST_WIDTH-1:0] i_push_data,
    output logic                            o_busy,
    output logic signed [REQUEST_WIDTH-1:0] o_best
);
    import vss_pkg::*;

    localparam int IW = $clog2(RING_DEPTH);
    localparam int CW = $clog2(RING_DEPTH + 1);

    logic signed [REQUEST_WIDTH-1:0] mem [RING_DEPTH];
    logic [RING_DEPTH-1:0]           r_vld;
    logic [IW-1:0]                   r_widx;
    logic [CW-1:0]                   r_addr;
    logic                            r_busy, r_rd_v, r_rd_vld, r_first;
    logic signed [REQUEST_WIDTH-1:0] r_rd_data, r_best;
    logic [REQUEST_WIDTH-1:0]        r_best_abs;
    logic signed [REQUEST_WIDTH-1:0] cur;
    logic [REQUEST_WIDTH-1:0]        cur_abs;
    logic                            take, rd_en;

    assign rd_en   = r_busy && !i_ctl.start && (r_addr != CW'(RING_DEPTH));
    assign cur     = r_rd_vld ? r_rd_data : '0;
    assign cur_abs = cur[REQUEST_WIDTH-1] ? REQUEST_WIDTH'(-cur) : cur;
    assign take    = r_first || (cur_abs > r_best_abs) ||
                     ((cur_abs == r_best_abs) && !cur[REQUEST_WIDTH-1] &&
                      r_best[REQUEST_WIDTH-1]);

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            mem[r_widx] <= i_push_data;
        end
        r_rd_data <= mem[r_addr[IW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_widx <= '0;
        end else begin
            if (i_ctl.clear) begin
                r_vld <= '0;
            end else if (i_ctl.push) begin
                r_vld[r_widx] <= 1'b1;
            end
            if (i_ctl.push) begin
                r_widx <= (r_widx == IW'(RING_DEPTH - 1)) ? '0 : r_widx + IW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_rd_v <= 1'b0;
            r_addr <= '0;
        end else if (i_ctl.start) begin
            r_busy <= 1'b1;
            r_rd_v <= 1'b0;
            r_addr <= '0;
        end else if (r_busy) begin
            r_rd_v <= rd_en;
            if (rd_en) begin
                r_addr <= r_addr + CW'(1);
            end else if (!r_rd_v) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_vld <= r_vld[r_addr[IW-1:0]];
        if (i_ctl.start) begin
            r_first <= 1'b1;
        end else if (r_rd_v) begin
            r_first <= 1'b0;
            if (take) begin
                r_best     <= cur;
                r_best_abs <= cur_abs;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_best = r_best;

endmodule

[sim/tb.sv]
// Self-checking testbench for the valve step sequencer core, directed table then random.
`timescale 1ns / 100ps

module tb;
    import vss_pkg::*;

    typedef struct {
        logic        cmd;
        logic [15:0] req;
        logic        run;
        logic        defrost;
        logic        busy;
        logic [11:0] err;
    } t_item;

    typedef struct {
        logic        mv;
        logic [16:0] steps;
        logic [2:0]  st;
        logic [15:0] pos;
    } t_valve_out;

    typedef struct {
        t_item      it;
        logic       known;
        t_valve_out res;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_index;
    logic [15:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_stall;
    logic        i_cmd;
    logic signed [15:0] i_step_request;
    logic        i_run_request;
    logic        i_defrost_request;
    logic        i_motor_busy;
    logic [11:0] i_abs_error;
    logic        o_out_valid;
    logic        i_out_stall;
    logic        o_move_valid;
    logic signed [16:0] o_move_steps;
    logic [2:0]  o_valve_state;
    logic [15:0] o_position;

    valve_step_sequencer_core dut (.*);

    // Predicted state of the sequencer.
    logic [15:0] cfg_regs [8];
    logic signed [15:0] ring [64];
    logic [5:0]  wr_idx;
    logic [2:0]  seq;
    logic        first_close;
    logic        frost_latch;
    logic [15:0] pos;
    logic [15:0] settle_cnt;
    logic [15:0] ival_cnt;

    t_valve_out  expected_moves[$];
    int          errors;
    int          shown;
    logic        hold_off;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #200ms;
        $display("== FAIL ==");
        $finish;
    end

    task automatic model_reset();
        cfg_regs[CFG_MIN_INTERVAL] = RST_MIN_INTERVAL;
        cfg_regs[CFG_MAX_INTERVAL] = RST_MAX_INTERVAL;
        cfg_regs[CFG_ERROR_GAIN]   = RST_ERROR_GAIN;
        cfg_regs[CFG_SETTLE]       = RST_SETTLE;
        cfg_regs[CFG_INIT_CLOSE]   = RST_INIT_CLOSE;
        cfg_regs[CFG_OPEN]         = RST_OPEN;
        cfg_regs[CFG_DEFROST_OPEN] = RST_DEFROST_OPEN;
        cfg_regs[CFG_CLOSE_INC]    = {8'd0, RST_CLOSE_INC};
        foreach (ring[k]) ring[k] = '0;
        wr_idx = '0;
        seq = VS_INIT;
        first_close = 1'b0;
        frost_latch = 1'b0;
        pos = '0;
        settle_cnt = '0;
        ival_cnt = '0;
    endtask

    function automatic logic [31:0] move_interval(input logic [11:0] err);
        logic [63:0] span;
        logic [63:0] den;
        if (cfg_regs[CFG_MAX_INTERVAL] <= cfg_regs[CFG_MIN_INTERVAL])
            return {16'd0, cfg_regs[CFG_MIN_INTERVAL]};
        span = 64'(cfg_regs[CFG_MAX_INTERVAL] - cfg_regs[CFG_MIN_INTERVAL]);
        den = 64'd4096 + 64'(cfg_regs[CFG_ERROR_GAIN]) * 64'(err);
        return 32'(cfg_regs[CFG_MIN_INTERVAL]) + 32'((span * 64'd4096) / den);
    endfunction

    function automatic t_valve_out advance_valve(input t_item it);
        t_valve_out r;
        int best;
        int cur;
        r.mv = 1'b0;
        r.steps = '0;
        if (it.cmd) begin
            ring[wr_idx] = it.req;
            wr_idx = wr_idx + 6'd1;
        end else begin
            if (settle_cnt != 16'hFFFF) settle_cnt++;
            if (ival_cnt != 16'hFFFF) ival_cnt++;
            if (it.defrost) begin
                if (!frost_latch && !it.busy) begin
                    frost_latch = 1'b1;
                    pos = '0;
                    r.mv = 1'b1;
                    r.steps = -17'(cfg_regs[CFG_DEFROST_OPEN]);
                    seq = VS_OPENING;
                end
            end else begin
                frost_latch = 1'b0;
                case (seq)
                    VS_CLOSING: begin
                        if (!it.busy) begin
                            if (first_close && it.run) begin
                                r.mv = 1'b1;
                                r.steps = -17'(cfg_regs[CFG_OPEN]);
                                seq = VS_OPENING;
                            end else begin
                                seq = VS_IDLE;
                            end
                            first_close = 1'b0;
                        end
                    end
                    VS_IDLE: begin
                        if (!it.busy && it.run) begin
                            r.mv = 1'b1;
                            r.steps = -17'(cfg_regs[CFG_OPEN]);
                            seq = VS_OPENING;
                        end
                    end
                    VS_OPENING: begin
                        if (!it.busy) begin
                            settle_cnt = '0;
                            seq = VS_REGULATE;
                        end
                    end
                    VS_REGULATE: begin
                        if (!it.run) begin
                            pos = pos + cfg_regs[CFG_CLOSE_INC][7:0];
                            r.mv = 1'b1;
                            r.steps = 17'(pos);
                            seq = VS_CLOSING;
                        end else if (settle_cnt >= cfg_regs[CFG_SETTLE] && !it.busy &&
                                     32'(ival_cnt) >= move_interval(it.err)) begin
                            best = ring[0];
                            for (int k = 1; k < 64; k++) begin
                                cur = ring[k];
                                if ((cur < 0 ? -cur : cur) > (best < 0 ? -best : best) ||
                                    ((cur < 0 ? -cur : cur) == (best < 0 ? -best : best)
                                     && cur > best))
                                    best = cur;
                            end
                            r.mv = 1'b1;
                            r.steps = 17'(best);
                            foreach (ring[k]) ring[k] = '0;
                            ival_cnt = '0;
                        end
                    end
                    default: begin
                        if (!it.busy) begin
                            pos = cfg_regs[CFG_INIT_CLOSE];
                            r.mv = 1'b1;
                            r.steps = 17'(cfg_regs[CFG_INIT_CLOSE]);
                            seq = VS_CLOSING;
                            first_close = 1'b1;
                        end
                    end
                endcase
            end
        end
        r.st = seq;
        r.pos = pos;
        return r;
    endfunction

    task automatic send_item(input t_item it, input logic known, input t_valve_out typed);
        t_valve_out r;
        if ($urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_cmd <= it.cmd;
        i_step_request <= it.req;
        i_run_request <= it.run;
        i_defrost_request <= it.defrost;
        i_motor_busy <= it.busy;
        i_abs_error <= it.err;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        r = advance_valve(it);
        expected_moves.push_back(known ? typed : r);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_CLOSE_INC) cfg_regs[idx] = {8'd0, val[7:0]};
        else cfg_regs[idx] = val;
        @(posedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (expected_moves.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    function automatic t_item tick(input logic run, input logic dfr, input logic busy,
                                   input logic [11:0] err);
        t_item it;
        it.cmd = 1'b0; it.req = '0; it.run = run; it.defrost = dfr;
        it.busy = busy; it.err = err;
        return it;
    endfunction

    function automatic t_item push(input logic [15:0] req);
        t_item it;
        it = tick(1'b1, 1'b0, 1'b0, 12'd0);
        it.cmd = 1'b1; it.req = req;
        return it;
    endfunction

    // Receiver: stalls on its own pattern, with one long hold-off.
    initial begin
        i_out_stall = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (hold_off) i_out_stall <= 1'b1;
            else i_out_stall <= ($urandom_range(0, 3) == 0);
        end
    end

    always @(posedge i_clk) begin
        t_valve_out e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_moves.size() == 0) begin
                errors++;
                if (shown < 10) begin
                    shown++;
                    $display("unexpected result transfer: mv=%0d steps=%0d", o_move_valid,
                             o_move_steps);
                end
            end else begin
                e = expected_moves.pop_front();
                if (e.mv !== o_move_valid || e.steps !== o_move_steps ||
                    e.st !== o_valve_state || e.pos !== o_position) begin
                    errors++;
                    if (shown < 10) begin
                        shown++;
                        $display({"mismatch: exp mv=%0d steps=%0d st=%0d pos=%0d, ",
                                  "got mv=%0d steps=%0d st=%0d pos=%0d"},
                                 e.mv, $signed(e.steps), e.st, e.pos, o_move_valid,
                                 o_move_steps, o_valve_state, o_position);
                    end
                end
            end
        end
    end

    t_row rows[$];

    task automatic add_row(input t_item it, input logic known, input logic mv,
                           input int steps, input logic [2:0] st, input logic [15:0] p);
        t_row r;
        r.it = it; r.known = known;
        r.res.mv = mv; r.res.steps = 17'(steps); r.res.st = st; r.res.pos = p;
        rows.push_back(r);
    endtask

    initial begin
        t_item it;
        t_valve_out none;
        int phase;
        int n;
        errors = 0;
        shown = 0;
        hold_off = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0; i_cfg_index = '0; i_cfg_data = '0;
        i_in_valid = 1'b0; i_cmd = 1'b0; i_step_request = '0;
        i_run_request = 1'b0; i_defrost_request = 1'b0; i_motor_busy = 1'b0;
        i_abs_error = '0;
        none.mv = 0; none.steps = 0; none.st = 0; none.pos = 0;
        model_reset();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: start-up, extremes, ties, defrost, busy and run drop.
        write_reg(CFG_SETTLE, 16'd0);
        write_reg(CFG_MIN_INTERVAL, 16'd0);
        write_reg(CFG_MAX_INTERVAL, 16'd0);
        add_row(push(16'h8000), 1, 0, 0, VS_INIT, 16'd0);
        add_row(tick(1, 0, 1, 0), 1, 0, 0, VS_INIT, 16'd0);
        add_row(tick(1, 0, 0, 0), 1, 1, 500, VS_CLOSING, 16'd500);
        add_row(tick(1, 0, 0, 0), 1, 1, -250, VS_OPENING, 16'd500);
        add_row(tick(1, 0, 0, 12'hFFF), 1, 0, 0, VS_REGULATE, 16'd500);
        add_row(push(16'h7FFF), 0, 0, 0, 0, 0);
        add_row(tick(1, 0, 0, 12'hFFF), 0, 0, 0, 0, 0);
        add_row(tick(1, 0, 0, 0), 0, 0, 0, 0, 0);
        add_row(push(16'h0005), 0, 0, 0, 0, 0);
        add_row(push(16'hFFFB), 0, 0, 0, 0, 0);
        add_row(tick(1, 0, 1, 0), 0, 0, 0, 0, 0);
        add_row(tick(1, 0, 0, 0), 0, 0, 0, 0, 0);
        add_row(tick(0, 0, 0, 0), 0, 0, 0, 0, 0);
        add_row(tick(0, 0, 0, 0), 0, 0, 0, 0, 0);
        add_row(tick(1, 1, 1, 0), 0, 0, 0, 0, 0);
        add_row(tick(1, 1, 0, 0), 0, 0, 0, 0, 0);
        add_row(tick(1, 1, 0, 0), 0, 0, 0, 0, 0);
        add_row(tick(1, 0, 0, 0), 0, 0, 0, 0, 0);
        add_row(tick(1, 0, 0, 0), 0, 0, 0, 0, 0);
        add_row(tick(0, 0, 0, 0), 0, 0, 0, 0, 0);
        add_row(tick(0, 0, 0, 0), 0, 0, 0, 0, 0);
        foreach (rows[k]) send_item(rows[k].it, rows[k].known, rows[k].res);
        drain();

        // Random phases over several register settings.
        for (phase = 0; phase < 7; phase++) begin
            case (phase)
                0: begin
                    write_reg(CFG_MIN_INTERVAL, 16'd2);
                    write_reg(CFG_MAX_INTERVAL, 16'd40);
                    write_reg(CFG_ERROR_GAIN, 16'd154);
                    write_reg(CFG_SETTLE, 16'd3);
                end
                1: begin
                    write_reg(CFG_ERROR_GAIN, 16'hFFFF);
                    write_reg(CFG_INIT_CLOSE, 16'hFFFF);
                    write_reg(CFG_OPEN, 16'hFFFF);
                    write_reg(CFG_DEFROST_OPEN, 16'hFFFF);
                    write_reg(CFG_CLOSE_INC, 16'h00FF);
                end
                2: begin
                    write_reg(CFG_ERROR_GAIN, 16'd0);
                    write_reg(CFG_MAX_INTERVAL, 16'd6);
                    write_reg(CFG_INIT_CLOSE, 16'd0);
                    write_reg(CFG_OPEN, 16'd0);
                    write_reg(CFG_DEFROST_OPEN, 16'd0);
                    write_reg(CFG_CLOSE_INC, 16'd0);
                end
                3: begin
                    write_reg(CFG_MIN_INTERVAL, 16'd9);
                    write_reg(CFG_MAX_INTERVAL, 16'd4);
                    write_reg(CFG_CLOSE_INC, 16'hAB37);
                end
                4: begin
                    write_reg(CFG_MIN_INTERVAL, 16'hFFFF);
                    write_reg(CFG_MAX_INTERVAL, 16'hFFFF);
                    write_reg(CFG_SETTLE, 16'hFFFF);
                end
                5: begin
                    write_reg(CFG_MIN_INTERVAL, 16'd0);
                    write_reg(CFG_MAX_INTERVAL, 16'hFFFF);
                    write_reg(CFG_ERROR_GAIN, 16'h5A5A);
                    write_reg(CFG_SETTLE, 16'd1);
                    write_reg(CFG_INIT_CLOSE, 16'h1234);
                    write_reg(CFG_OPEN, 16'h00A5);
                    write_reg(CFG_DEFROST_OPEN, 16'h5AA5);
                    write_reg(CFG_CLOSE_INC, 16'd16);
                end
                default: begin
                    write_reg(CFG_MIN_INTERVAL, 16'd1);
                    write_reg(CFG_MAX_INTERVAL, 16'd3);
                    write_reg(CFG_SETTLE, 16'd0);
                end
            endcase
            if (phase == 3) begin
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (600) @(posedge i_clk);
                        hold_off = 1'b0;
                    end
                join_none
            end
            for (n = 0; n < 100; n++) begin
                if ($urandom_range(0, 2) == 0) begin
                    it = push(16'($urandom));
                    if ($urandom_range(0, 7) == 0) it.req = 16'h8000;
                    if ($urandom_range(0, 7) == 0) it.req = 16'h7FFF;
                end else begin
                    it = tick($urandom_range(0, 15) != 0, $urandom_range(0, 19) == 0,
                              $urandom_range(0, 5) == 0, 12'($urandom));
                end
                send_item(it, 1'b0, none);
            end
            drain();
        end

        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
